// ===== hw/rtl/tcpop_pkg.sv =====
// Shared types and constants for the TCP option parser.
`timescale 1ns / 1ps
package tcpop_pkg;

    // Option kinds
    localparam logic [7:0] KIND_EOL       = 8'd0;
    localparam logic [7:0] KIND_NOP       = 8'd1;
    localparam logic [7:0] KIND_MSS       = 8'd2;
    localparam logic [7:0] KIND_WSCALE    = 8'd3;
    localparam logic [7:0] KIND_SACK_PERM = 8'd4;
    localparam logic [7:0] KIND_SACK      = 8'd5;
    localparam logic [7:0] KIND_TIMESTAMP = 8'd8;
    localparam logic [7:0] KIND_MD5       = 8'd19;

    // Option lengths, counting kind and length bytes
    localparam logic [7:0] OPT_LEN_MIN       = 8'd2;
    localparam logic [7:0] OPT_LEN_MSS       = 8'd4;
    localparam logic [7:0] OPT_LEN_WSCALE    = 8'd3;
    localparam logic [7:0] OPT_LEN_SACK_PERM = 8'd2;

    // Fixed part of the TCP header and the largest option region
    localparam logic [5:0] TCP_BASE_HDR_BYTES = 6'd20;
    localparam logic [3:0] TCP_BASE_HDR_WORDS = 4'd5;
    localparam logic [5:0] MAX_REGION_BYTES   = 6'd40;

    // Bit positions in the found-options flag register
    localparam int FLAG_MSS       = 0;
    localparam int FLAG_WSCALE    = 1;
    localparam int FLAG_SACK_PERM = 2;
    localparam int FLAG_SACK      = 3;
    localparam int FLAG_TIMESTAMP = 4;
    localparam int FLAG_MD5       = 5;
    localparam int FLAG_COUNT     = 6;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_KIND = 2'd1,
        PH_LEN  = 2'd2,
        PH_BODY = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        END_EXHAUSTED = 2'd0,
        END_EOL       = 2'd1,
        END_SHORT_LEN = 2'd2,
        END_PARTIAL   = 2'd3
    } end_reason_t;

    typedef struct packed {
        logic [7:0] option_byte;
        logic       first_byte;
        logic [3:0] header_words;
        logic       syn_flag;
    } opt_in_t;

    typedef struct packed {
        logic        mss_valid;
        logic [15:0] mss_value;
        logic        wscale_valid;
        logic [7:0]  wscale_value;
        logic        sack_permitted;
        logic        sack_seen;
        logic [5:0]  sack_length;
        logic        timestamp_seen;
        logic        md5_seen;
        logic [1:0]  end_reason;
    } opt_out_t;

    // Result handed from the parser to the output queue
    typedef struct packed {
        logic     push;
        opt_out_t data;
    } result_push_t;

endpackage

// ===== hw/rtl/tcpop_parse.sv =====
// Per-segment option parse state and the single-byte step logic.
`timescale 1ns / 1ps
module tcpop_parse (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    fire,
    input  tcpop_pkg::opt_in_t      item,
    output tcpop_pkg::result_push_t result
);

    tcpop_pkg::phase_t phase_reg, phase_next, eff_phase;
    logic [5:0]  bytes_left_reg, bytes_left_next, eff_bytes;
    logic [7:0]  kind_reg, kind_next, eff_kind;
    logic [5:0]  body_left_reg, body_left_next, eff_body;
    logic [5:0]  opt_size_reg, opt_size_next, eff_size;
    logic        syn_reg, syn_next, eff_syn;
    logic [15:0] mss_reg, mss_next, eff_mss;
    logic [tcpop_pkg::FLAG_COUNT-1:0] flags_reg, flags_next, eff_flags;
    logic [7:0]  wscale_reg, wscale_next, eff_wscale;
    logic [5:0]  sack_len_reg, sack_len_next, eff_sack_len;

    logic        early_end;
    logic        tail;
    logic [5:0]  body_v;
    logic [5:0]  bytes_v;
    logic [5:0]  body_idx;
    logic        res_hit;
    tcpop_pkg::end_reason_t res_reason;
    logic [7:0]  ob;

    assign ob = item.option_byte;

    // A first byte clears the segment state before it is parsed
    always_comb
    begin
        eff_phase    = phase_reg;
        eff_bytes    = bytes_left_reg;
        eff_kind     = kind_reg;
        eff_body     = body_left_reg;
        eff_size     = opt_size_reg;
        eff_syn      = syn_reg;
        eff_mss      = mss_reg;
        eff_flags    = flags_reg;
        eff_wscale   = wscale_reg;
        eff_sack_len = sack_len_reg;
        early_end    = 1'b0;
        if (item.first_byte)
        begin
            eff_phase    = tcpop_pkg::PH_IDLE;
            eff_bytes    = '0;
            eff_kind     = '0;
            eff_body     = '0;
            eff_size     = '0;
            eff_syn      = item.syn_flag;
            eff_mss      = '0;
            eff_flags    = '0;
            eff_wscale   = '0;
            eff_sack_len = '0;
            if (item.header_words <= tcpop_pkg::TCP_BASE_HDR_WORDS)
            begin
                early_end = 1'b1;
            end
            else
            begin
                eff_bytes = {item.header_words, 2'b00} - tcpop_pkg::TCP_BASE_HDR_BYTES;
                eff_phase = tcpop_pkg::PH_KIND;
            end
        end
    end

    always_comb
    begin
        phase_next    = eff_phase;
        bytes_left_next = eff_bytes;
        kind_next     = eff_kind;
        body_left_next = eff_body;
        opt_size_next = eff_size;
        syn_next      = eff_syn;
        mss_next      = eff_mss;
        flags_next    = eff_flags;
        wscale_next   = eff_wscale;
        sack_len_next = eff_sack_len;
        res_hit       = 1'b0;
        res_reason    = tcpop_pkg::END_EXHAUSTED;
        tail          = 1'b0;
        body_v        = eff_body;
        bytes_v       = eff_bytes;
        body_idx      = eff_size - tcpop_pkg::OPT_LEN_MIN[5:0] - eff_body;

        if (early_end)
        begin
            res_hit    = 1'b1;
            res_reason = tcpop_pkg::END_EXHAUSTED;
            phase_next = tcpop_pkg::PH_IDLE;
        end
        else
        begin
            case (eff_phase)
                tcpop_pkg::PH_KIND:
                begin
                    if (ob == tcpop_pkg::KIND_EOL)
                    begin
                        res_hit    = 1'b1;
                        res_reason = tcpop_pkg::END_EOL;
                    end
                    else if (ob == tcpop_pkg::KIND_NOP)
                    begin
                        bytes_left_next = eff_bytes - 6'd1;
                        if (bytes_left_next == 6'd0)
                        begin
                            res_hit    = 1'b1;
                            res_reason = tcpop_pkg::END_EXHAUSTED;
                        end
                    end
                    else if (eff_bytes <= 6'd1)
                    begin
                        // kind in the last region byte: no room for a length
                        res_hit    = 1'b1;
                        res_reason = tcpop_pkg::END_PARTIAL;
                    end
                    else
                    begin
                        kind_next  = ob;
                        phase_next = tcpop_pkg::PH_LEN;
                    end
                end
                tcpop_pkg::PH_LEN:
                begin
                    if (ob < tcpop_pkg::OPT_LEN_MIN)
                    begin
                        res_hit    = 1'b1;
                        res_reason = tcpop_pkg::END_SHORT_LEN;
                    end
                    else if (ob > {2'b00, eff_bytes})
                    begin
                        res_hit    = 1'b1;
                        res_reason = tcpop_pkg::END_PARTIAL;
                    end
                    else
                    begin
                        // length fits the region, so it fits six bits
                        opt_size_next = ob[5:0];
                        body_v  = ob[5:0] - tcpop_pkg::OPT_LEN_MIN[5:0];
                        bytes_v = eff_bytes - ob[5:0];
                        tail    = 1'b1;
                        if (eff_kind == tcpop_pkg::KIND_MSS && ob == tcpop_pkg::OPT_LEN_MSS
                            && eff_syn)
                        begin
                            flags_next[tcpop_pkg::FLAG_MSS] = 1'b1;
                            mss_next = '0;
                        end
                        else if (eff_kind == tcpop_pkg::KIND_WSCALE
                                 && ob == tcpop_pkg::OPT_LEN_WSCALE && eff_syn)
                        begin
                            flags_next[tcpop_pkg::FLAG_WSCALE] = 1'b1;
                            wscale_next = '0;
                        end
                        else if (eff_kind == tcpop_pkg::KIND_SACK_PERM
                                 && ob == tcpop_pkg::OPT_LEN_SACK_PERM && eff_syn)
                        begin
                            flags_next[tcpop_pkg::FLAG_SACK_PERM] = 1'b1;
                        end
                        else if (eff_kind == tcpop_pkg::KIND_SACK)
                        begin
                            flags_next[tcpop_pkg::FLAG_SACK] = 1'b1;
                            sack_len_next = ob[5:0];
                        end
                        else if (eff_kind == tcpop_pkg::KIND_TIMESTAMP)
                        begin
                            flags_next[tcpop_pkg::FLAG_TIMESTAMP] = 1'b1;
                        end
                        else if (eff_kind == tcpop_pkg::KIND_MD5)
                        begin
                            flags_next[tcpop_pkg::FLAG_MD5] = 1'b1;
                        end
                    end
                end
                tcpop_pkg::PH_BODY:
                begin
                    if (eff_kind == tcpop_pkg::KIND_MSS
                        && eff_size == tcpop_pkg::OPT_LEN_MSS[5:0] && eff_syn)
                    begin
                        if (body_idx == 6'd0)
                        begin
                            mss_next = {ob, eff_mss[7:0]};
                        end
                        else if (body_idx == 6'd1)
                        begin
                            mss_next = {eff_mss[15:8], ob};
                        end
                    end
                    else if (eff_kind == tcpop_pkg::KIND_WSCALE
                             && eff_size == tcpop_pkg::OPT_LEN_WSCALE[5:0] && eff_syn)
                    begin
                        if (body_idx == 6'd0)
                        begin
                            wscale_next = ob;
                        end
                    end
                    body_v = eff_body - 6'd1;
                    tail   = 1'b1;
                end
                default:
                begin
                    // idle: drop bytes that trail a finished parse
                end
            endcase

            if (tail)
            begin
                body_left_next  = body_v;
                bytes_left_next = bytes_v;
                if (body_v != 6'd0)
                begin
                    phase_next = tcpop_pkg::PH_BODY;
                end
                else if (bytes_v == 6'd0)
                begin
                    res_hit    = 1'b1;
                    res_reason = tcpop_pkg::END_EXHAUSTED;
                end
                else
                begin
                    phase_next = tcpop_pkg::PH_KIND;
                end
            end

            if (res_hit)
            begin
                phase_next = tcpop_pkg::PH_IDLE;
            end
        end
    end

    // Summary from the updated holds, value fields masked by their flags
    always_comb
    begin
        result.push = fire && res_hit;
        result.data.mss_valid      = flags_next[tcpop_pkg::FLAG_MSS];
        result.data.mss_value      = flags_next[tcpop_pkg::FLAG_MSS] ? mss_next : 16'd0;
        result.data.wscale_valid   = flags_next[tcpop_pkg::FLAG_WSCALE];
        result.data.wscale_value   = flags_next[tcpop_pkg::FLAG_WSCALE] ? wscale_next : 8'd0;
        result.data.sack_permitted = flags_next[tcpop_pkg::FLAG_SACK_PERM];
        result.data.sack_seen      = flags_next[tcpop_pkg::FLAG_SACK];
        result.data.sack_length    = flags_next[tcpop_pkg::FLAG_SACK] ? sack_len_next : 6'd0;
        result.data.timestamp_seen = flags_next[tcpop_pkg::FLAG_TIMESTAMP];
        result.data.md5_seen       = flags_next[tcpop_pkg::FLAG_MD5];
        result.data.end_reason     = res_reason;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= tcpop_pkg::PH_IDLE;
            bytes_left_reg <= '0;
            kind_reg       <= '0;
            body_left_reg  <= '0;
            opt_size_reg   <= '0;
            syn_reg        <= 1'b0;
            mss_reg        <= '0;
            flags_reg      <= '0;
            wscale_reg     <= '0;
            sack_len_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            kind_reg       <= kind_next;
            body_left_reg  <= body_left_next;
            opt_size_reg   <= opt_size_next;
            syn_reg        <= syn_next;
            mss_reg        <= mss_next;
            flags_reg      <= flags_next;
            wscale_reg     <= wscale_next;
            sack_len_reg   <= sack_len_next;
        end
    end

    a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        result.push |=> phase_reg == tcpop_pkg::PH_IDLE)
        else $error("parser not idle after issuing a summary");

    a_region_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bytes_left_reg <= tcpop_pkg::MAX_REGION_BYTES)
        else $error("bytes left exceeds the largest option region");

endmodule

// ===== hw/rtl/tcpop_out_fifo.sv =====
// Two-entry result queue that decouples the parser from a stalling receiver.
`timescale 1ns / 1ps
module tcpop_out_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  tcpop_pkg::result_push_t result,
    output logic                    can_push,
    output logic                    result_valid,
    input  logic                    result_stall,
    output tcpop_pkg::opt_out_t     result_data
);

    tcpop_pkg::opt_out_t entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign can_push     = (count_reg != 2'd2);
    assign result_valid = (count_reg != 2'd0);
    assign result_data  = entry_reg[rd_ptr_reg];
    assign pop          = result_valid && !result_stall;

    always_comb
    begin
        count_next = count_reg;
        if (result.push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !result.push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.push)
        begin
            entry_reg[wr_ptr_reg] <= result.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (result.push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("result queue holds more than two entries");

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        result.push && !pop |=> count_reg == $past(count_reg) + 2'd1)
        else $error("pushed summary not counted");

endmodule

// ===== hw/rtl/tcp_option_parser.sv =====
// Top level of the TCP option parser: input register, parser and result queue.
`timescale 1ns / 1ps
// Usage:
//   Option bytes enter on the byte channel (byte_valid, byte_stall, byte_data),
//   one per transaction, in header order. first_byte marks the start of a
//   segment; header_words and syn_flag are sampled with it.
//   At most one summary per segment leaves on the result channel (result_valid,
//   result_stall, result_data) when the parse ends: EOL, region exhausted,
//   a bad length or a partial option. Bytes after the end are dropped.
//   Timing: an accepted byte is held in the input register and parsed from
//   there; its summary, if any, is written into the result queue and offered.
//   Throughput: one byte per cycle while the result queue has room; the parse
//   step between the input register and the two-entry result queue is combinational.
//   Stall: a stalled result stays in the queue; the parser keeps taking
//   bytes until the queue is full, then byte_stall rises and holds the
//   pending byte in the input register.
//   Reset: asynchronous, active low; clears the parse state and empties
//   the queue, ready for a first byte straight away.
module tcp_option_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  tcpop_pkg::opt_in_t  byte_data,
    output logic                result_valid,
    input  logic                result_stall,
    output tcpop_pkg::opt_out_t result_data
);

    logic                    s1_valid_reg;
    tcpop_pkg::opt_in_t      s1_item_reg;
    logic                    can_push;
    logic                    fire;
    logic                    accept;
    tcpop_pkg::result_push_t result;

    assign fire       = s1_valid_reg && can_push;
    assign byte_stall = s1_valid_reg && !can_push;
    assign accept     = byte_valid && !byte_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= byte_data;
        end
    end

    tcpop_parse u_parse (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (s1_item_reg),
        .result (result)
    );

    tcpop_out_fifo u_out_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .result       (result),
        .can_push     (can_push),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the TCP option parser: byte stimulus, summary prediction and checks.
`timescale 1ns / 1ps
module tb;

    localparam int RANDOM_BYTES = 1925;
    localparam int CALM_TAIL    = 250;
    localparam int CYCLE_LIMIT  = 300000;

    // Tracks the parse of each segment and holds the summaries still owed by the block
    class summary_tracker;
        tcpop_pkg::opt_out_t   summaries_due[$];
        int                    fails;
        tcpop_pkg::phase_t     phase;
        logic [5:0]            bytes_left;
        logic [7:0]            kind;
        logic [5:0]            body_left;
        logic [5:0]            opt_size;
        logic                  seg_syn;
        logic [15:0]           mss_accum;
        logic [tcpop_pkg::FLAG_COUNT-1:0] found;
        logic [7:0]            wscale_hold;
        logic [5:0]            sack_len_hold;

        function new();
            fails = 0;
            clear_state();
        endfunction

        function void clear_state();
            phase         = tcpop_pkg::PH_IDLE;
            bytes_left    = '0;
            kind          = '0;
            body_left     = '0;
            opt_size      = '0;
            seg_syn       = 1'b0;
            mss_accum     = '0;
            found         = '0;
            wscale_hold   = '0;
            sack_len_hold = '0;
        endfunction

        function void close_segment(tcpop_pkg::end_reason_t why);
            tcpop_pkg::opt_out_t s;
            s                = '0;
            s.mss_valid      = found[tcpop_pkg::FLAG_MSS];
            s.mss_value      = found[tcpop_pkg::FLAG_MSS] ? mss_accum : 16'd0;
            s.wscale_valid   = found[tcpop_pkg::FLAG_WSCALE];
            s.wscale_value   = found[tcpop_pkg::FLAG_WSCALE] ? wscale_hold : 8'd0;
            s.sack_permitted = found[tcpop_pkg::FLAG_SACK_PERM];
            s.sack_seen      = found[tcpop_pkg::FLAG_SACK];
            s.sack_length    = found[tcpop_pkg::FLAG_SACK] ? sack_len_hold : 6'd0;
            s.timestamp_seen = found[tcpop_pkg::FLAG_TIMESTAMP];
            s.md5_seen       = found[tcpop_pkg::FLAG_MD5];
            s.end_reason     = why;
            summaries_due.push_back(s);
            phase = tcpop_pkg::PH_IDLE;
        endfunction

        function void take_byte(tcpop_pkg::opt_in_t b);
            logic [7:0] ob;
            logic [5:0] idx;
            ob = b.option_byte;
            if (b.first_byte)
            begin
                // a new segment abandons any parse in progress
                clear_state();
                seg_syn = b.syn_flag;
                if (b.header_words <= tcpop_pkg::TCP_BASE_HDR_WORDS)
                begin
                    close_segment(tcpop_pkg::END_EXHAUSTED);
                    return;
                end
                bytes_left = {b.header_words, 2'b00} - tcpop_pkg::TCP_BASE_HDR_BYTES;
                phase = tcpop_pkg::PH_KIND;
            end
            case (phase)
                tcpop_pkg::PH_IDLE:
                begin
                    return;
                end
                tcpop_pkg::PH_KIND:
                begin
                    if (ob == tcpop_pkg::KIND_EOL)
                    begin
                        close_segment(tcpop_pkg::END_EOL);
                        return;
                    end
                    if (ob == tcpop_pkg::KIND_NOP)
                    begin
                        bytes_left = bytes_left - 6'd1;
                        if (bytes_left == 0)
                            close_segment(tcpop_pkg::END_EXHAUSTED);
                        return;
                    end
                    if (bytes_left <= 1)
                    begin
                        close_segment(tcpop_pkg::END_PARTIAL);
                        return;
                    end
                    kind  = ob;
                    phase = tcpop_pkg::PH_LEN;
                    return;
                end
                tcpop_pkg::PH_LEN:
                begin
                    if (ob < tcpop_pkg::OPT_LEN_MIN)
                    begin
                        close_segment(tcpop_pkg::END_SHORT_LEN);
                        return;
                    end
                    // the length counts the kind byte, which is still in bytes_left
                    if (ob > bytes_left)
                    begin
                        close_segment(tcpop_pkg::END_PARTIAL);
                        return;
                    end
                    opt_size   = ob[5:0];
                    body_left  = ob[5:0] - tcpop_pkg::OPT_LEN_MIN[5:0];
                    bytes_left = bytes_left - ob[5:0];
                    if (kind == tcpop_pkg::KIND_MSS && ob == tcpop_pkg::OPT_LEN_MSS && seg_syn)
                    begin
                        found[tcpop_pkg::FLAG_MSS] = 1'b1;
                        mss_accum = '0;
                    end
                    else if (kind == tcpop_pkg::KIND_WSCALE
                             && ob == tcpop_pkg::OPT_LEN_WSCALE && seg_syn)
                    begin
                        found[tcpop_pkg::FLAG_WSCALE] = 1'b1;
                        wscale_hold = '0;
                    end
                    else if (kind == tcpop_pkg::KIND_SACK_PERM
                             && ob == tcpop_pkg::OPT_LEN_SACK_PERM && seg_syn)
                        found[tcpop_pkg::FLAG_SACK_PERM] = 1'b1;
                    else if (kind == tcpop_pkg::KIND_SACK)
                    begin
                        found[tcpop_pkg::FLAG_SACK] = 1'b1;
                        sack_len_hold = ob[5:0];
                    end
                    else if (kind == tcpop_pkg::KIND_TIMESTAMP)
                        found[tcpop_pkg::FLAG_TIMESTAMP] = 1'b1;
                    else if (kind == tcpop_pkg::KIND_MD5)
                        found[tcpop_pkg::FLAG_MD5] = 1'b1;
                end
                tcpop_pkg::PH_BODY:
                begin
                    idx = opt_size - 6'd2 - body_left;
                    if (kind == tcpop_pkg::KIND_MSS && opt_size == tcpop_pkg::OPT_LEN_MSS
                        && seg_syn)
                    begin
                        if (idx == 0)
                            mss_accum[15:8] = ob;
                        else if (idx == 1)
                            mss_accum[7:0] = ob;
                    end
                    else if (kind == tcpop_pkg::KIND_WSCALE
                             && opt_size == tcpop_pkg::OPT_LEN_WSCALE && seg_syn && idx == 0)
                        wscale_hold = ob;
                    body_left = body_left - 6'd1;
                end
                default:
                begin
                    return;
                end
            endcase
            if (body_left != 0)
                phase = tcpop_pkg::PH_BODY;
            else if (bytes_left == 0)
                close_segment(tcpop_pkg::END_EXHAUSTED);
            else
                phase = tcpop_pkg::PH_KIND;
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                fails++;
            end
        endfunction

        function void check_summary(tcpop_pkg::opt_out_t got);
            tcpop_pkg::opt_out_t want;
            if (summaries_due.size() == 0)
            begin
                $error("summary with none outstanding: %p", got);
                fails++;
                return;
            end
            want = summaries_due.pop_front();
            compare_field("mss_valid", 16'(want.mss_valid), 16'(got.mss_valid));
            compare_field("mss_value", want.mss_value, got.mss_value);
            compare_field("wscale_valid", 16'(want.wscale_valid), 16'(got.wscale_valid));
            compare_field("wscale_value", 16'(want.wscale_value), 16'(got.wscale_value));
            compare_field("sack_permitted", 16'(want.sack_permitted),
                          16'(got.sack_permitted));
            compare_field("sack_seen", 16'(want.sack_seen), 16'(got.sack_seen));
            compare_field("sack_length", 16'(want.sack_length), 16'(got.sack_length));
            compare_field("timestamp_seen", 16'(want.timestamp_seen),
                          16'(got.timestamp_seen));
            compare_field("md5_seen", 16'(want.md5_seen), 16'(got.md5_seen));
            compare_field("end_reason", 16'(want.end_reason), 16'(got.end_reason));
        endfunction
    endclass

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                byte_valid   = 1'b0;
    logic                byte_stall;
    tcpop_pkg::opt_in_t  byte_data    = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    tcpop_pkg::opt_out_t result_data;

    bit             calm = 1'b0;
    logic [7:0]     seg_bytes[$];
    summary_tracker tracker = new();

    tcp_option_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one byte and hold it until the transaction completes
    task automatic push_byte(bit first, logic [3:0] hw, bit syn, logic [7:0] ob);
        tcpop_pkg::opt_in_t item;
        item.option_byte  = ob;
        item.first_byte   = first;
        item.header_words = first ? hw : 4'($urandom);
        item.syn_flag     = first ? syn : 1'($urandom);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_data  <= item;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        tracker.take_byte(item);
    endtask

    task automatic send_segment(logic [3:0] hw, bit syn);
        foreach (seg_bytes[i])
            push_byte(i == 0, hw, syn, seg_bytes[i]);
    endtask

    function automatic logic [7:0] body_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Append one option, or a NOP where it does not fit; return the room left
    function automatic int add_option(logic [7:0] kind, int len, int room);
        if (len > room || len < 2)
        begin
            seg_bytes.push_back(tcpop_pkg::KIND_NOP);
            return room - 1;
        end
        seg_bytes.push_back(kind);
        seg_bytes.push_back(8'(len));
        repeat (len - 2)
            seg_bytes.push_back(body_byte());
        return room - len;
    endfunction

    // Build one segment in seg_bytes; return the bytes that the parse should consume
    function automatic int plan_segment(output logic [3:0] hw, output bit syn);
        int room;
        int core;
        int cut;
        int pick;
        seg_bytes.delete();
        core = -1;
        syn  = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 49) == 0)
        begin
            hw = 4'($urandom_range(0, tcpop_pkg::TCP_BASE_HDR_WORDS));
            seg_bytes.push_back(8'($urandom_range(0, 255)));
            return 1;
        end
        hw   = 4'($urandom_range(6, 15));
        room = hw * 4 - tcpop_pkg::TCP_BASE_HDR_BYTES;
        while (room > 0)
        begin
            case ($urandom_range(0, 10))
                0, 10: room = add_option(tcpop_pkg::KIND_NOP, 1, room);
                1:
                begin
                    seg_bytes.push_back(tcpop_pkg::KIND_EOL);
                    core = seg_bytes.size();
                    // pad the rest of the region with zeros, as senders do
                    repeat (room - 1)
                        seg_bytes.push_back(tcpop_pkg::KIND_EOL);
                    room = 0;
                end
                2: room = add_option(tcpop_pkg::KIND_MSS, tcpop_pkg::OPT_LEN_MSS, room);
                3: room = add_option(tcpop_pkg::KIND_WSCALE, tcpop_pkg::OPT_LEN_WSCALE, room);
                4: room = add_option(tcpop_pkg::KIND_SACK_PERM, tcpop_pkg::OPT_LEN_SACK_PERM,
                                     room);
                5: room = add_option(tcpop_pkg::KIND_SACK, 2 + 8 * $urandom_range(1, 4), room);
                6: room = add_option(tcpop_pkg::KIND_TIMESTAMP, 10, room);
                7: room = add_option(tcpop_pkg::KIND_MD5, 18, room);
                8: room = add_option(8'($urandom_range(2, 255)), $urandom_range(2, room), room);
                9: room = add_option(8'($urandom_range(tcpop_pkg::KIND_MSS,
                                                        tcpop_pkg::KIND_SACK)),
                                     $urandom_range(2, 6), room);
                default: ;
            endcase
        end
        if (core < 0)
            core = seg_bytes.size();
        pick = $urandom_range(0, 9);
        case (pick)
            0: seg_bytes[$urandom_range(0, seg_bytes.size() - 1)] = 8'($urandom_range(0, 255));
            1: seg_bytes[$urandom_range(0, seg_bytes.size() - 1)] = 8'($urandom_range(0, 3));
            2:
            begin
                // cut short: the next segment restarts the parse
                cut = $urandom_range(1, seg_bytes.size());
                seg_bytes = seg_bytes[0:cut - 1];
                if (core > cut)
                    core = cut;
            end
            3:
            begin
                foreach (seg_bytes[i])
                    seg_bytes[i] = 8'($urandom_range(0, 255));
            end
            4:
            begin
                repeat ($urandom_range(1, 4))
                    seg_bytes.push_back(8'($urandom_range(0, 255)));
            end
            default: ;
        endcase
        return core;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            tracker.check_summary(result_data);
    end

    initial
    begin
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
                result_stall <= 1'b1;
            else
                result_stall <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    end

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tcp_option_parser test failed");
        $finish;
    end

    initial
    begin
        int         sent;
        int         stretch;
        logic [3:0] hw;
        bit         syn;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        seg_bytes = '{tcpop_pkg::KIND_MSS, tcpop_pkg::OPT_LEN_MSS, 8'hFF, 8'hFF};
        send_segment(4'd6, 1'b1);
        seg_bytes = '{tcpop_pkg::KIND_WSCALE, tcpop_pkg::OPT_LEN_WSCALE, 8'hFF,
                      tcpop_pkg::KIND_NOP, tcpop_pkg::KIND_SACK_PERM,
                      tcpop_pkg::OPT_LEN_SACK_PERM, tcpop_pkg::KIND_EOL};
        send_segment(4'd7, 1'b1);
        // empty region
        seg_bytes = '{8'hFF};
        send_segment(tcpop_pkg::TCP_BASE_HDR_WORDS, 1'b1);
        // length under two, then a stray byte once the parse is over
        seg_bytes = '{tcpop_pkg::KIND_SACK, 8'd1};
        send_segment(4'd6, 1'b0);
        push_byte(1'b0, 4'd0, 1'b0, 8'hA5);
        // length past the end of the region
        seg_bytes = '{tcpop_pkg::KIND_TIMESTAMP, 8'd10};
        send_segment(4'd6, 1'b0);
        // kind in the last byte of the region
        seg_bytes = '{tcpop_pkg::KIND_NOP, tcpop_pkg::KIND_NOP, tcpop_pkg::KIND_NOP,
                      tcpop_pkg::KIND_MD5};
        send_segment(4'd6, 1'b0);
        // abandon a parse with a new segment
        seg_bytes = '{tcpop_pkg::KIND_TIMESTAMP};
        send_segment(4'd15, 1'b1);
        seg_bytes = '{tcpop_pkg::KIND_SACK, 8'd4, 8'h00, 8'hFF};
        send_segment(4'd6, 1'b0);

        sent    = 0;
        stretch = -1;
        while (sent < RANDOM_BYTES)
        begin
            if (sent >= RANDOM_BYTES - CALM_TAIL)
                calm = 1'b1;
            else if (sent / 150 != stretch)
            begin
                stretch = sent / 150;
                calm = ($urandom_range(0, 4) == 0);
            end
            void'(plan_segment(hw, syn));
            sent += seg_bytes.size();
            send_segment(hw, syn);
        end
        byte_valid <= 1'b0;

        while (tracker.summaries_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (tracker.fails == 0)
            $display("tcp_option_parser test passed");
        else
            $display("tcp_option_parser test failed");
        $finish;
    end
endmodule

// ===== tcp_option_parser.f =====
hw/rtl/tcpop_pkg.sv
hw/rtl/tcpop_parse.sv
hw/rtl/tcpop_out_fifo.sv
hw/rtl/tcp_option_parser.sv
tb/tb.sv
